// ----- rtl/lkvc_pkg.sv -----
package lkvc_pkg;

  localparam int KEY_BITS = 32;
  localparam int VALUE_BITS = 32;
  localparam int ENTRIES_DEF = 16;
  localparam int CAP_BITS = 5;
  localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_SET = 1'b1;

  typedef struct packed {
    logic                         cmd;
    logic signed [KEY_BITS-1:0]   key;
    logic signed [VALUE_BITS-1:0] data_in;
  } req_t;

  typedef struct packed {
    logic                         hit;
    logic signed [VALUE_BITS-1:0] data_out;
    logic                         evicted;
    logic signed [KEY_BITS-1:0]   evicted_key;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DECIDE,
    ST_EVICT
  } state_t;

endpackage

// ----- rtl/lkvc_store.sv -----
module lkvc_store
  import lkvc_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEF,
  parameter int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic                  clk,
  input  logic                  wr_key_en,
  input  logic                  wr_val_en,
  input  logic [IW-1:0]         wr_addr,
  input  logic [KEY_BITS-1:0]   wr_key,
  input  logic [VALUE_BITS-1:0] wr_val,
  input  logic [IW-1:0]         rd_addr,
  output logic [KEY_BITS-1:0]   rd_key,
  output logic [VALUE_BITS-1:0] rd_val
);

  logic [KEY_BITS-1:0]   key_mem [ENTRIES];
  logic [VALUE_BITS-1:0] val_mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (wr_key_en) begin
      key_mem[wr_addr] <= wr_key;
    end
    rd_key <= key_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (wr_val_en) begin
      val_mem[wr_addr] <= wr_val;
    end
    rd_val <= val_mem[rd_addr];
  end

endmodule

// ----- rtl/lru_key_value_cache_core.sv -----
// A word's result strobes once the scan of all entries, the drain state and the decide
// state are through, and the evict state too when a set has to evict the least recent entry.
// The core takes one word at a time; its pace is set by the scan of the key memory
// through its single read port, one entry per cycle.
// Reset clears the valid marks, ranks, count and state, and sets capacity to 16.
// Results cannot be held off by the receiver; done is high for one cycle per word.
module lru_key_value_cache_core
  import lkvc_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  req_t                req,
  output logic                done,
  output rsp_t                rsp,
  input  logic                cfg_we,
  input  logic [CAP_BITS-1:0] cfg_data
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int EW = (CW > CAP_BITS) ? CW : CAP_BITS;
  localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);
  localparam logic [EW-1:0] ENT_EXT = EW'(ENTRIES);

  state_t state, state_next;

  logic [CAP_BITS-1:0] capacity;
  req_t                cur;
  logic [IW-1:0]       scan_idx;
  logic [IW-1:0]       cmp_idx;
  logic                cmp_vld;
  logic                found;
  logic [IW-1:0]       found_idx;
  logic [VALUE_BITS-1:0] found_val;
  logic [IW-1:0]       found_age;
  logic                free_ok;
  logic [IW-1:0]       free_idx;
  logic                vic_ok;
  logic [IW-1:0]       vic_idx;
  logic [ENTRIES-1:0]  entry_valid;
  logic [IW-1:0]       entry_age [ENTRIES];
  logic [CW-1:0]       entry_count;

  logic [KEY_BITS-1:0]   rd_key;
  logic [VALUE_BITS-1:0] rd_val;
  logic [IW-1:0]         rd_addr;
  logic                  wr_key_en;
  logic                  wr_val_en;
  logic [IW-1:0]         wr_addr;

  logic [EW-1:0] cap_ext;
  logic [EW-1:0] cap_eff;
  logic [EW-1:0] count_ext;
  logic          full;
  logic          room_after_evict;

  logic    touch_en;
  logic    ins_en;
  logic    evict_en;
  logic [IW-1:0] ins_idx;
  logic    rsp_load;
  rsp_t    rsp_next;

  assign cap_ext = EW'(capacity);
  assign cap_eff = (cap_ext > ENT_EXT) ? ENT_EXT : cap_ext;
  assign count_ext = EW'(entry_count);
  assign full = count_ext >= cap_eff;
  assign room_after_evict = (count_ext - EW'(1)) < cap_eff;
  assign busy = (state != ST_IDLE);

  lkvc_store #(
    .ENTRIES (ENTRIES),
    .IW      (IW)
  ) u_store (
    .clk       (clk),
    .wr_key_en (wr_key_en),
    .wr_val_en (wr_val_en),
    .wr_addr   (wr_addr),
    .wr_key    (cur.key),
    .wr_val    (cur.data_in),
    .rd_addr   (rd_addr),
    .rd_key    (rd_key),
    .rd_val    (rd_val)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_idx == LAST_IDX) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (!found && cur.cmd == CMD_SET && full && vic_ok) begin
          state_next = ST_EVICT;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_EVICT: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    rd_addr   = scan_idx;
    wr_key_en = 1'b0;
    wr_val_en = 1'b0;
    wr_addr   = found_idx;
    touch_en  = 1'b0;
    ins_en    = 1'b0;
    evict_en  = 1'b0;
    ins_idx   = free_idx;
    rsp_load  = 1'b0;
    rsp_next  = '0;
    unique case (state)
      ST_DECIDE: begin
        rd_addr  = vic_idx;
        rsp_load = 1'b1;
        if (found) begin
          touch_en     = 1'b1;
          rsp_next.hit = 1'b1;
          if (cur.cmd == CMD_SET) begin
            wr_val_en = 1'b1;
          end else begin
            rsp_next.data_out = found_val;
          end
        end else if (cur.cmd == CMD_SET && !full) begin
          ins_en    = 1'b1;
          wr_key_en = 1'b1;
          wr_val_en = 1'b1;
          wr_addr   = free_idx;
        end else if (cur.cmd == CMD_SET && vic_ok) begin
          rsp_load = 1'b0;
        end
      end
      ST_EVICT: begin
        rsp_load             = 1'b1;
        evict_en             = 1'b1;
        rsp_next.evicted     = 1'b1;
        rsp_next.evicted_key = rd_key;
        ins_idx = (free_ok && free_idx < vic_idx) ? free_idx : vic_idx;
        if (room_after_evict) begin
          ins_en    = 1'b1;
          wr_key_en = 1'b1;
          wr_val_en = 1'b1;
          wr_addr   = ins_idx;
        end
      end
      default: begin
        rd_addr = scan_idx;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      capacity <= CAP_RESET;
      done     <= 1'b0;
      cmp_vld  <= 1'b0;
    end else begin
      state   <= state_next;
      done    <= rsp_load;
      cmp_vld <= (state == ST_SCAN);
      if (cfg_we) begin
        capacity <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp <= rsp_next;
    end
    if (state == ST_IDLE) begin
      cur      <= req;
      scan_idx <= '0;
      found    <= 1'b0;
      free_ok  <= 1'b0;
      vic_ok   <= 1'b0;
    end else begin
      if (state == ST_SCAN && scan_idx != LAST_IDX) begin
        scan_idx <= scan_idx + IW'(1);
      end
      if (state == ST_SCAN) begin
        cmp_idx <= scan_idx;
      end
      if (cmp_vld) begin
        if (entry_valid[cmp_idx] && rd_key == cur.key && !found) begin
          found     <= 1'b1;
          found_idx <= cmp_idx;
          found_val <= rd_val;
          found_age <= entry_age[cmp_idx];
        end
        if (!entry_valid[cmp_idx] && !free_ok) begin
          free_ok  <= 1'b1;
          free_idx <= cmp_idx;
        end
        if (entry_valid[cmp_idx] && CW'(entry_age[cmp_idx]) == entry_count - CW'(1)) begin
          vic_ok  <= 1'b1;
          vic_idx <= cmp_idx;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      entry_count <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        entry_age[i] <= '0;
      end
    end else begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (touch_en) begin
          if (IW'(i) == found_idx) begin
            entry_age[i] <= '0;
          end else if (entry_valid[i] && entry_age[i] < found_age) begin
            entry_age[i] <= entry_age[i] + IW'(1);
          end
        end else if (ins_en && IW'(i) == ins_idx) begin
          entry_valid[i] <= 1'b1;
          entry_age[i]   <= '0;
        end else if (evict_en && IW'(i) == vic_idx) begin
          entry_valid[i] <= 1'b0;
          entry_age[i]   <= '0;
        end else if (ins_en && entry_valid[i]) begin
          entry_age[i] <= entry_age[i] + IW'(1);
        end
      end
      if (ins_en && !evict_en) begin
        entry_count <= entry_count + CW'(1);
      end else if (evict_en && !ins_en) begin
        entry_count <= entry_count - CW'(1);
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without a word in progress");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    CW'(entry_count) <= CW'(ENTRIES))
    else $error("entry count exceeds the number of entries");

  a_count_matches_valid: assert property (@(posedge clk) disable iff (rst)
    !busy |-> ($countones(entry_valid) == int'(entry_count)))
    else $error("entry count disagrees with the valid marks");

  a_evict_not_hit: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.evicted) |-> !rsp.hit)
    else $error("eviction reported on a hit");
`endif

endmodule
